// ===== design/cvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvd_pkg: shared types and constants for the chunk verifier / descrambler
// Holds the register map, the front-end configuration bundle and the work
// entry that travels through the queue from front end to back end.
// ----------------------------------------------------------------------------
package cvd_pkg;

  // Largest chunk that is accepted as well-formed
  localparam int unsigned MaxChunk      = 1024;
  // Password bytes the descrambler can cycle through
  localparam int unsigned PasswordBytes = 32;
  // Depth of the queue between front end and back end
  localparam int unsigned FifoDepth     = 4;

  localparam int unsigned PwPosW   = 5;
  localparam int unsigned PwLenW   = 6;
  localparam int unsigned PwBits   = 256;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Checksum addends for a nonzero byte
  localparam logic [7:0] AddMaskHit  = 8'h24;
  localparam logic [7:0] AddMaskMiss = 8'h33;
  // Top bit pattern for the walking descramble mask
  localparam logic [7:0] WalkTop     = 8'h80;
  localparam logic [7:0] WalkBottom  = 8'h01;

  // Reset values of the configuration registers
  localparam logic [7:0]  PolarityReset = 8'h80;
  localparam logic [31:0] CarryReset    = 32'h8000_0000;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CfgPolarity = 3'd0,
    CfgCarry    = 3'd1,
    CfgPwLen    = 3'd2,
    CfgPwA      = 3'd3,
    CfgPwB      = 3'd4,
    CfgPwC      = 3'd5,
    CfgPwD      = 3'd6
  } cfg_idx_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [7:0]        polarity_mask;
    logic [PwLenW-1:0] pw_len;
    logic [PwBits-1:0] pw;
  } front_cfg_t;

  // One classified byte on its way to the back end
  typedef struct packed {
    logic [7:0]  decoded;
    logic [7:0]  data;
    logic [15:0] addend;
    logic        in_chunk;
    logic        start;
    logic        last;
    logic        first_of_image;
    logic [31:0] expected;
    logic        oversize;
  } work_t;

endpackage

// ===== design/cvd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvd stream interfaces
// Valid/ready channels for encoded input bytes and for decoded result bytes.
// ----------------------------------------------------------------------------
interface cvd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_chunk;
  logic        first_of_image;
  logic [15:0] chunk_size;
  logic [31:0] expected_chunk_sum;

  modport source (output valid, data_byte, first_of_chunk, first_of_image, chunk_size,
                  expected_chunk_sum, input ready);
  modport sink (input valid, data_byte, first_of_chunk, first_of_image, chunk_size,
                expected_chunk_sum, output ready);
endinterface

interface cvd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  decoded_byte;
  logic        last_of_chunk;
  logic [31:0] chunk_sum;
  logic        chunk_ok;
  logic        size_error;
  logic [31:0] image_sum;

  modport source (output valid, decoded_byte, last_of_chunk, chunk_sum, chunk_ok,
                  size_error, image_sum, input ready);
  modport sink (input valid, decoded_byte, last_of_chunk, chunk_sum, chunk_ok,
                size_error, image_sum, output ready);
endinterface

// ===== design/cvd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvd_front: byte intake and classification
// Tracks chunk framing and positions, descrambles each byte and works out its
// checksum addend, then pushes one work entry into the queue.
// ----------------------------------------------------------------------------
module cvd_front #(
  parameter int unsigned MaxChunk      = cvd_pkg::MaxChunk,
  parameter int unsigned PasswordBytes = cvd_pkg::PasswordBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cvd_pkg::front_cfg_t cfg_i,
  cvd_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output cvd_pkg::work_t      push_data_o
);

  logic [15:0]                  rem_q, rem_d;
  logic [7:0]                   bpos_q, bpos_d;
  logic [cvd_pkg::PwPosW-1:0]   ppos_q, ppos_d;
  logic [31:0]                  exp_q, exp_d;
  logic                         over_q, over_d;

  logic                         accept;
  logic [15:0]                  size_eff;
  logic [15:0]                  rem_cur;
  logic [7:0]                   bpos_cur;
  logic [cvd_pkg::PwPosW-1:0]   ppos_cur;
  logic [31:0]                  exp_cur;
  logic                         over_cur;
  logic [cvd_pkg::PwLenW-1:0]   pw_len;
  logic [cvd_pkg::PwLenW-1:0]   ppos_inc;
  logic [7:0]                   pw_byte;
  logic [2:0]                   walk;
  logic [7:0]                   decoded;
  logic                         in_chunk;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  // Pick the chunk context: fresh on the first byte, held otherwise
  always_comb begin
    size_eff = (in_i.chunk_size == 16'd0) ? 16'd1 : in_i.chunk_size;
    if (in_i.first_of_chunk) begin
      rem_cur  = size_eff;
      bpos_cur = 8'd0;
      ppos_cur = '0;
      exp_cur  = in_i.expected_chunk_sum;
      over_cur = (size_eff > 16'(MaxChunk));
    end else begin
      rem_cur  = rem_q;
      bpos_cur = bpos_q;
      ppos_cur = ppos_q;
      exp_cur  = exp_q;
      over_cur = over_q;
    end
  end

  // Descramble and advance the positions
  always_comb begin
    pw_len   = (cfg_i.pw_len > cvd_pkg::PwLenW'(PasswordBytes)) ?
               cvd_pkg::PwLenW'(PasswordBytes) : cfg_i.pw_len;
    pw_byte  = cfg_i.pw[{ppos_cur, 3'b000} +: 8];
    ppos_inc = {1'b0, ppos_cur} + cvd_pkg::PwLenW'(1);
    walk     = bpos_cur[2:0];

    if (pw_len == '0) begin
      ppos_d = ppos_cur;
    end else if (ppos_inc >= pw_len) begin
      ppos_d = '0;
    end else begin
      ppos_d = ppos_inc[cvd_pkg::PwPosW-1:0];
    end
    bpos_d = bpos_cur + 8'd1;

    decoded = in_i.data_byte
            ^ ((pw_len != '0) ? pw_byte : 8'd0)
            ^ (cvd_pkg::WalkTop >> walk)
            ^ (cvd_pkg::WalkBottom << walk)
            ^ bpos_cur;
  end

  // Classify the byte for the checksum
  always_comb begin
    in_chunk = (rem_cur != 16'd0);
    rem_d    = in_chunk ? (rem_cur - 16'd1) : rem_cur;
    exp_d    = exp_cur;
    over_d   = over_cur;

    push_data_o.decoded        = decoded;
    push_data_o.data           = in_i.data_byte;
    push_data_o.in_chunk       = in_chunk;
    push_data_o.start          = in_i.first_of_chunk;
    push_data_o.last           = in_chunk && (rem_cur == 16'd1);
    push_data_o.first_of_image = in_i.first_of_image;
    push_data_o.expected       = exp_cur;
    push_data_o.oversize       = over_cur;
    if (in_i.data_byte == 8'd0) begin
      push_data_o.addend = rem_cur;
    end else if ((in_i.data_byte & cfg_i.polarity_mask) != 8'd0) begin
      push_data_o.addend = {8'd0, cvd_pkg::AddMaskHit};
    end else begin
      push_data_o.addend = {8'd0, cvd_pkg::AddMaskMiss};
    end
  end

  // Update framing state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      bpos_q <= '0;
      ppos_q <= '0;
      exp_q  <= '0;
      over_q <= 1'b0;
    end else if (accept) begin
      rem_q  <= rem_d;
      bpos_q <= bpos_d;
      ppos_q <= ppos_d;
      exp_q  <= exp_d;
      over_q <= over_d;
    end
  end

endmodule

// ===== design/cvd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvd_fifo: work queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cvd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cvd_pkg::work_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cvd_pkg::work_t head_o
);

  localparam int unsigned PtrW = $clog2(cvd_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(cvd_pkg::FifoDepth + 1);

  cvd_pkg::work_t    mem_q [cvd_pkg::FifoDepth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(cvd_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(cvd_pkg::FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(cvd_pkg::FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/cvd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvd_back: checksum engine and result stage
// Three stages: accumulate the chunk sum, close it with the zero count, then
// fold it into the image sum and compare against the expected value.
// ----------------------------------------------------------------------------
module cvd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    carry_mask_i,
  input  logic           empty_i,
  input  cvd_pkg::work_t head_i,
  output logic           pop_o,
  cvd_out_if.source      out_o
);

  logic        en;

  // Accumulate stage
  logic [31:0] acc_q, acc_d;
  logic [15:0] zc_q, zc_d;
  logic        a_valid_q;
  logic        a_last_q;
  logic        a_foi_q;
  logic [7:0]  a_dec_q;
  logic [31:0] a_exp_q;
  logic        a_over_q;
  logic [31:0] acc_base;
  logic [15:0] zc_base;
  logic [31:0] acc_add;
  logic [31:0] acc_rot;

  // Close stage
  logic        b_valid_q;
  logic        b_last_q;
  logic        b_foi_q;
  logic [7:0]  b_dec_q;
  logic [31:0] b_exp_q;
  logic        b_over_q;
  logic [31:0] b_sum_q;

  // Result stage
  logic        c_valid_q;
  logic        c_last_q;
  logic [7:0]  c_dec_q;
  logic [31:0] c_sum_q;
  logic        c_ok_q;
  logic        c_over_q;
  logic [31:0] c_img_q;
  logic [31:0] img_q, img_d;
  logic [31:0] img_base;

  // Move the whole pipe when the result register can take a new transaction
  assign en    = !c_valid_q || out_o.ready;
  assign pop_o = en && !empty_i;

  // Apply one byte to the chunk accumulator
  always_comb begin
    acc_base = head_i.start ? 32'd0 : acc_q;
    zc_base  = head_i.start ? 16'd0 : zc_q;
    acc_add  = acc_base + {16'd0, head_i.addend};
    acc_rot  = {acc_add[30:0], ((acc_add & carry_mask_i) != 32'd0)};
    acc_d    = acc_q;
    zc_d     = zc_q;
    if (head_i.in_chunk) begin
      acc_d = acc_rot + {24'd0, head_i.data};
      zc_d  = zc_base + {15'd0, (head_i.data == 8'd0)};
    end
  end

  // Fold the finished chunk into the image sum
  always_comb begin
    img_base = b_foi_q ? 32'd0 : img_q;
    img_d    = b_last_q ? (img_base + b_sum_q) : img_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      zc_q      <= '0;
      img_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= pop_o;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      if (pop_o) begin
        acc_q <= acc_d;
        zc_q  <= zc_d;
      end
      if (b_valid_q) begin
        img_q <= img_d;
      end
    end
  end

  // Payload moves with the pipe
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_last_q <= head_i.last;
      a_foi_q  <= head_i.first_of_image;
      a_dec_q  <= head_i.decoded;
      a_exp_q  <= head_i.expected;
      a_over_q <= head_i.oversize;

      b_last_q <= a_last_q;
      b_foi_q  <= a_foi_q;
      b_dec_q  <= a_dec_q;
      b_exp_q  <= a_exp_q;
      b_over_q <= a_over_q;
      b_sum_q  <= acc_q + {16'd0, zc_q};

      c_last_q <= b_last_q;
      c_dec_q  <= b_dec_q;
      c_sum_q  <= b_last_q ? b_sum_q : 32'd0;
      c_ok_q   <= b_last_q && !b_over_q && (b_sum_q == b_exp_q);
      c_over_q <= b_last_q && b_over_q;
      c_img_q  <= b_last_q ? img_d : 32'd0;
    end
  end

  assign out_o.valid         = c_valid_q;
  assign out_o.decoded_byte  = c_dec_q;
  assign out_o.last_of_chunk = c_last_q;
  assign out_o.chunk_sum     = c_sum_q;
  assign out_o.chunk_ok      = c_ok_q;
  assign out_o.size_error    = c_over_q;
  assign out_o.image_sum     = c_img_q;

endmodule

// ===== design/chunk_verify_and_descramble_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_verify_and_descramble_top: firmware chunk checker and descrambler
// Verifies per-chunk checksums of an encoded image and returns every byte
// descrambled, with chunk and image sums reported on the last byte.
// ----------------------------------------------------------------------------
// One byte is taken per clock and one result leaves per clock when the sink
// keeps ready high. The front end decodes a byte in the cycle it is accepted
// and writes it to a four-entry queue; the back end's three-stage checksum
// pipe (accumulate, close, result) takes bytes from the queue, each stage
// registered. The chunk accumulator update (add, shift left with masked
// carry bit, add) is the feedback loop that sets the byte rate. Input ready
// drops only when the queue is full. Write configuration only while no
// bytes are in flight; password_length above 32 acts as 32 and chunk sizes
// above 1024 are flagged with size_error.
// ----------------------------------------------------------------------------
module chunk_verify_and_descramble_top #(
  parameter int unsigned MaxChunk      = cvd_pkg::MaxChunk,
  parameter int unsigned PasswordBytes = cvd_pkg::PasswordBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cvd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cvd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cvd_in_if.sink                        in_i,
  cvd_out_if.source                     out_o
);

  logic [7:0]                   polarity_q;
  logic [31:0]                  carry_q;
  logic [cvd_pkg::PwLenW-1:0]   pw_len_q;
  logic [cvd_pkg::PwBits-1:0]   pw_q;

  cvd_pkg::front_cfg_t          front_cfg;
  cvd_pkg::work_t               push_data;
  cvd_pkg::work_t               head;
  logic                         push;
  logic                         pop;
  logic                         full;
  logic                         empty;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q <= cvd_pkg::PolarityReset;
      carry_q    <= cvd_pkg::CarryReset;
      pw_len_q   <= '0;
      pw_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvd_pkg::CfgPolarity: polarity_q    <= cfg_wdata_i[7:0];
        cvd_pkg::CfgCarry:    carry_q       <= cfg_wdata_i[31:0];
        cvd_pkg::CfgPwLen:    pw_len_q      <= cfg_wdata_i[cvd_pkg::PwLenW-1:0];
        cvd_pkg::CfgPwA:      pw_q[63:0]    <= cfg_wdata_i;
        cvd_pkg::CfgPwB:      pw_q[127:64]  <= cfg_wdata_i;
        cvd_pkg::CfgPwC:      pw_q[191:128] <= cfg_wdata_i;
        cvd_pkg::CfgPwD:      pw_q[255:192] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign front_cfg.polarity_mask = polarity_q;
  assign front_cfg.pw_len        = pw_len_q;
  assign front_cfg.pw            = pw_q;

  cvd_front #(
    .MaxChunk      (MaxChunk),
    .PasswordBytes (PasswordBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (front_cfg),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cvd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  cvd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .carry_mask_i (carry_q),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
